/* design/jclc_pkg.sv */
// ---------------------------------------------------------------------------
// Joystick cursor and LED controller package
// Shared constants, field widths and codes for the cursor and LED controller.
// ---------------------------------------------------------------------------
package jclc_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 10;
    localparam int POS_X_W  = 7;
    localparam int POS_Y_W  = 6;
    localparam int LEVEL_W  = 12;
    localparam int STEP_W   = 7;
    localparam int CFG_IDX_W = 1;

    // Tuning constants
    localparam int DEAD_ZONE   = 500;
    localparam int STEP_MIN    = 8;
    localparam int STEP_MAX    = 16;
    localparam int SQUARE_SIDE = 8;
    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 64;
    localparam int MID         = 2048;
    localparam int FULL_LEVEL  = 4000;

    // Reset values of the debounce registers
    localparam int STICK_DEB_RST = 50;
    localparam int BTN_A_DEB_RST = 80;

    // Command, button and register index codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_BUTTON = 1'b1;
    localparam logic BTN_STICK  = 1'b0;
    localparam logic BTN_A      = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_A_DEB = 1'b1;

    // Screen room and centre positions
    localparam int X_ROOM   = SCREEN_W - SQUARE_SIDE;
    localparam int Y_ROOM   = SCREEN_H - SQUARE_SIDE;
    localparam int X_CENTRE = (X_ROOM > 0) ? X_ROOM / 2 : 0;
    localparam int Y_CENTRE = (Y_ROOM > 0) ? Y_ROOM / 2 : 0;
    localparam int X_MAX    = (X_ROOM > 0) ? X_ROOM : 0;
    localparam int Y_MAX    = (Y_ROOM > 0) ? Y_ROOM : 0;

    // Constant division by the span beyond the dead zone is done as a
    // multiplication by a rounded-up reciprocal. With 2^SHIFT above the
    // square of the span the quotient is exact for every deflection.
    localparam int      DEN         = MID - DEAD_ZONE;
    localparam int      RECIP_SHIFT = 24;
    localparam longint  LVL_MUL_L   =
        ((longint'(1) << RECIP_SHIFT) * FULL_LEVEL + DEN - 1) / DEN;
    localparam longint  STEP_MUL_L  =
        ((longint'(1) << RECIP_SHIFT) * (STEP_MAX - STEP_MIN) + DEN - 1) / DEN;
    localparam logic [31:0] LVL_MUL  = LVL_MUL_L[31:0];
    localparam logic [31:0] STEP_MUL = STEP_MUL_L[31:0];
    localparam int      PROD_W      = SAMPLE_W + 32;

    // Per-axis result of the deflection logic
    typedef struct packed {
        logic                neg;    // deflection below the dead zone
        logic                pos;    // deflection above the dead zone
        logic [STEP_W-1:0]   step;
        logic [LEVEL_W-1:0]  level;
    } t_axis;

endpackage

/* design/joystick_cursor_led_controller_top.sv */
// ---------------------------------------------------------------------------
// Joystick cursor and LED controller
// Moves a square cursor from joystick samples, drives red and blue LED levels
// from the deflection and toggles border and LED enable on debounced buttons.
// ---------------------------------------------------------------------------
// Pipeline: an item passes the input register, then the result register; while
// the result register is stalled, the item waits in the input register.
// Throughput: one item per cycle while results are taken; the only path is the
// short update logic between the input register and the result register.
// Reset: synchronous, active low; cursor centred, levels zero, LEDs enabled,
// border off, timestamps zero, debounce registers at 50 ms and 80 ms.
module joystick_cursor_led_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [jclc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [jclc_pkg::DEB_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic [jclc_pkg::SAMPLE_W-1:0]     i_x_sample,
    input  logic [jclc_pkg::SAMPLE_W-1:0]     i_y_sample,
    input  logic                              i_button_id,
    input  logic                              i_falling_edge,
    input  logic [jclc_pkg::TIME_W-1:0]       i_time_ms,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [jclc_pkg::POS_X_W-1:0]      o_square_x,
    output logic [jclc_pkg::POS_Y_W-1:0]      o_square_y,
    output logic [jclc_pkg::LEVEL_W-1:0]      o_red_level,
    output logic [jclc_pkg::LEVEL_W-1:0]      o_blue_level,
    output logic                              o_border_on,
    output logic                              o_leds_enabled
);

    // Configuration registers
    logic [jclc_pkg::DEB_W-1:0]    r_stick_deb;
    logic [jclc_pkg::DEB_W-1:0]    r_btn_a_deb;

    // Input register
    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [jclc_pkg::SAMPLE_W-1:0] r_in_x;
    logic [jclc_pkg::SAMPLE_W-1:0] r_in_y;
    logic                          r_in_button;
    logic                          r_in_falling;
    logic [jclc_pkg::TIME_W-1:0]   r_in_time;

    // Controller state
    logic [jclc_pkg::POS_X_W-1:0]  r_pos_x;
    logic [jclc_pkg::POS_Y_W-1:0]  r_pos_y;
    logic [jclc_pkg::LEVEL_W-1:0]  r_red_hold;
    logic [jclc_pkg::LEVEL_W-1:0]  r_blue_hold;
    logic                          r_drive_enable;
    logic                          r_border_flag;
    logic [jclc_pkg::TIME_W-1:0]   r_stick_last;
    logic [jclc_pkg::TIME_W-1:0]   r_btn_a_last;

    // Next state
    logic [jclc_pkg::POS_X_W-1:0]  n_pos_x;
    logic [jclc_pkg::POS_Y_W-1:0]  n_pos_y;
    logic [jclc_pkg::LEVEL_W-1:0]  n_red_hold;
    logic [jclc_pkg::LEVEL_W-1:0]  n_blue_hold;
    logic                          n_drive_enable;
    logic                          n_border_flag;
    logic [jclc_pkg::TIME_W-1:0]   n_stick_last;
    logic [jclc_pkg::TIME_W-1:0]   n_btn_a_last;

    // Result register
    logic                          r_out_valid;
    logic [jclc_pkg::POS_X_W-1:0]  r_out_x;
    logic [jclc_pkg::POS_Y_W-1:0]  r_out_y;
    logic [jclc_pkg::LEVEL_W-1:0]  r_out_red;
    logic [jclc_pkg::LEVEL_W-1:0]  r_out_blue;
    logic                          r_out_border;
    logic                          r_out_leds;

    logic                          adv;
    logic                          fire;
    jclc_pkg::t_axis               ax_x;
    jclc_pkg::t_axis               ax_y;

    // Handshake: the input stage moves on whenever the result stage is free
    assign adv     = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || adv;
    assign fire    = r_in_valid && adv;

    // Per-axis deflection, step and LED level
    function automatic jclc_pkg::t_axis axis_eval(input logic [jclc_pkg::SAMPLE_W-1:0] s);
        logic signed [jclc_pkg::SAMPLE_W:0]   dev;
        logic [jclc_pkg::SAMPLE_W-1:0]        mag;
        logic [jclc_pkg::SAMPLE_W-1:0]        over;
        logic                                 outside;
        logic [jclc_pkg::PROD_W-1:0]          lvl_prod;
        logic [jclc_pkg::PROD_W-1:0]          step_prod;
        jclc_pkg::t_axis                      res;
        dev       = $signed({1'b0, s}) - $signed((jclc_pkg::SAMPLE_W+1)'(jclc_pkg::MID));
        mag       = dev[jclc_pkg::SAMPLE_W] ? jclc_pkg::SAMPLE_W'(-dev)
                                            : jclc_pkg::SAMPLE_W'(dev);
        outside   = mag > jclc_pkg::SAMPLE_W'(jclc_pkg::DEAD_ZONE);
        over      = outside ? (mag - jclc_pkg::SAMPLE_W'(jclc_pkg::DEAD_ZONE))
                            : '0;
        lvl_prod  = jclc_pkg::PROD_W'(over) * jclc_pkg::PROD_W'(jclc_pkg::LVL_MUL);
        step_prod = jclc_pkg::PROD_W'(over) * jclc_pkg::PROD_W'(jclc_pkg::STEP_MUL);
        res.neg   = outside && dev[jclc_pkg::SAMPLE_W];
        res.pos   = outside && !dev[jclc_pkg::SAMPLE_W];
        res.level = lvl_prod[jclc_pkg::RECIP_SHIFT +: jclc_pkg::LEVEL_W];
        res.step  = step_prod[jclc_pkg::RECIP_SHIFT +: jclc_pkg::STEP_W]
                  + jclc_pkg::STEP_W'(jclc_pkg::STEP_MIN);
        return res;
    endfunction

    assign ax_x = axis_eval(r_in_x);
    assign ax_y = axis_eval(r_in_y);

    // Update logic for the item held in the input register
    always_comb begin
        n_pos_x        = r_pos_x;
        n_pos_y        = r_pos_y;
        n_red_hold     = r_red_hold;
        n_blue_hold    = r_blue_hold;
        n_drive_enable = r_drive_enable;
        n_border_flag  = r_border_flag;
        n_stick_last   = r_stick_last;
        n_btn_a_last   = r_btn_a_last;
        case (r_in_cmd)
            jclc_pkg::CMD_SAMPLE: begin
                if (!ax_x.neg && !ax_x.pos && !ax_y.neg && !ax_y.pos) begin
                    n_pos_x = jclc_pkg::POS_X_W'(jclc_pkg::X_CENTRE);
                    n_pos_y = jclc_pkg::POS_Y_W'(jclc_pkg::Y_CENTRE);
                end else begin
                    // An axis moves only if the whole step fits on screen
                    if (ax_x.neg && (10'(r_pos_x) >= 10'(ax_x.step))) begin
                        n_pos_x = r_pos_x - jclc_pkg::POS_X_W'(ax_x.step);
                    end else if (ax_x.pos && ($signed(10'(r_pos_x) + 10'(ax_x.step))
                                 <= $signed(10'(jclc_pkg::X_ROOM)))) begin
                        n_pos_x = r_pos_x + jclc_pkg::POS_X_W'(ax_x.step);
                    end
                    // Y is inverted: a low reading moves the square down
                    if (ax_y.neg && ($signed(10'(r_pos_y) + 10'(ax_y.step))
                                 <= $signed(10'(jclc_pkg::Y_ROOM)))) begin
                        n_pos_y = r_pos_y + jclc_pkg::POS_Y_W'(ax_y.step);
                    end else if (ax_y.pos && (10'(r_pos_y) >= 10'(ax_y.step))) begin
                        n_pos_y = r_pos_y - jclc_pkg::POS_Y_W'(ax_y.step);
                    end
                end
                if (r_drive_enable) begin
                    n_red_hold  = ax_x.level;
                    n_blue_hold = ax_y.level;
                end
            end
            jclc_pkg::CMD_BUTTON: begin
                // Debounce on the wrapping time since the last accepted edge
                if (r_in_button == jclc_pkg::BTN_STICK) begin
                    if ((r_in_time - r_stick_last) > jclc_pkg::TIME_W'(r_stick_deb)) begin
                        if (r_in_falling) begin
                            n_border_flag = !r_border_flag;
                        end
                        n_stick_last = r_in_time;
                    end
                end else begin
                    if ((r_in_time - r_btn_a_last) > jclc_pkg::TIME_W'(r_btn_a_deb)) begin
                        if (r_in_falling) begin
                            n_drive_enable = !r_drive_enable;
                        end
                        n_btn_a_last = r_in_time;
                    end
                end
            end
            default: begin
                n_pos_x = r_pos_x;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_deb <= jclc_pkg::DEB_W'(jclc_pkg::STICK_DEB_RST);
            r_btn_a_deb <= jclc_pkg::DEB_W'(jclc_pkg::BTN_A_DEB_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jclc_pkg::CFG_STICK_DEB: r_stick_deb <= i_cfg_data;
                jclc_pkg::CFG_BTN_A_DEB: r_btn_a_deb <= i_cfg_data;
                default: r_stick_deb <= r_stick_deb;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd     <= i_cmd;
            r_in_x       <= i_x_sample;
            r_in_y       <= i_y_sample;
            r_in_button  <= i_button_id;
            r_in_falling <= i_falling_edge;
            r_in_time    <= i_time_ms;
        end
    end

    // Controller state, updated as the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x        <= jclc_pkg::POS_X_W'(jclc_pkg::X_CENTRE);
            r_pos_y        <= jclc_pkg::POS_Y_W'(jclc_pkg::Y_CENTRE);
            r_red_hold     <= '0;
            r_blue_hold    <= '0;
            r_drive_enable <= 1'b1;
            r_border_flag  <= 1'b0;
            r_stick_last   <= '0;
            r_btn_a_last   <= '0;
        end else if (fire) begin
            r_pos_x        <= n_pos_x;
            r_pos_y        <= n_pos_y;
            r_red_hold     <= n_red_hold;
            r_blue_hold    <= n_blue_hold;
            r_drive_enable <= n_drive_enable;
            r_border_flag  <= n_border_flag;
            r_stick_last   <= n_stick_last;
            r_btn_a_last   <= n_btn_a_last;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_x      <= n_pos_x;
            r_out_y      <= n_pos_y;
            r_out_red    <= n_red_hold;
            r_out_blue   <= n_blue_hold;
            r_out_border <= n_border_flag;
            r_out_leds   <= n_drive_enable;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_square_x     = r_out_x;
    assign o_square_y     = r_out_y;
    assign o_red_level    = r_out_red;
    assign o_blue_level   = r_out_blue;
    assign o_border_on    = r_out_border;
    assign o_leds_enabled = r_out_leds;

    // The square always stays within the screen
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pos_x) <= jclc_pkg::X_MAX) && (32'(r_pos_y) <= jclc_pkg::Y_MAX))
        else $error("cursor position left the screen");

    // LED levels never exceed full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_red_hold) <= jclc_pkg::FULL_LEVEL) &&
        (32'(r_blue_hold) <= jclc_pkg::FULL_LEVEL))
        else $error("LED level above full scale");

    // A sample never touches the button flags
    a_sample_keeps_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_cmd == jclc_pkg::CMD_SAMPLE) |=>
        ($stable(r_border_flag) && $stable(r_drive_enable)))
        else $error("sample changed a button flag");

    // A button edge never moves the square
    a_button_keeps_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_cmd == jclc_pkg::CMD_BUTTON) |=>
        ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("button edge moved the square");

    // A transfer leaves a result waiting in the result register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("item lost between stages");

endmodule

/* tb/joystick_cursor_led_controller_top_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Joystick cursor and LED controller testbench
// Drives sample pairs and button edges into the controller and compares every
// result transfer against a typed directed result or a cycle-free model of the
// cursor, LED levels and debounced buttons. A short directed table comes first.
// Random phases follow, each with its own debounce and sender/receiver idling.
// ---------------------------------------------------------------------------
module joystick_cursor_led_controller_top_test;

    // Home position of the square, worked out from the screen geometry.
    localparam int HOME_X = jclc_pkg::X_CENTRE;
    localparam int HOME_Y = jclc_pkg::Y_CENTRE;
    localparam int SAMPLE_TOP = (1 << jclc_pkg::SAMPLE_W) - 1;
    localparam int PHASE_ITEMS = 425;

    // One input item: {cmd, x, y, button, falling, time}.
    typedef struct packed {
        logic                            cmd;
        logic [jclc_pkg::SAMPLE_W-1:0]   x;
        logic [jclc_pkg::SAMPLE_W-1:0]   y;
        logic                            btn;
        logic                            fall;
        logic [jclc_pkg::TIME_W-1:0]     t;
    } t_stick_item;

    // One result item: {square x, square y, red, blue, border, leds}.
    typedef struct packed {
        logic [jclc_pkg::POS_X_W-1:0]    sq_x;
        logic [jclc_pkg::POS_Y_W-1:0]    sq_y;
        logic [jclc_pkg::LEVEL_W-1:0]    red;
        logic [jclc_pkg::LEVEL_W-1:0]    blue;
        logic                            border;
        logic                            leds;
    } t_cursor_state;

    typedef struct packed {
        t_stick_item           item;
        logic                  typed;
        t_cursor_state         want;
    } t_table_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [jclc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = jclc_pkg::CFG_STICK_DEB;
    logic [jclc_pkg::DEB_W-1:0]      i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic                            i_cmd = jclc_pkg::CMD_SAMPLE;
    logic [jclc_pkg::SAMPLE_W-1:0]   i_x_sample = '0;
    logic [jclc_pkg::SAMPLE_W-1:0]   i_y_sample = '0;
    logic                            i_button_id = jclc_pkg::BTN_STICK;
    logic                            i_falling_edge = 1'b0;
    logic [jclc_pkg::TIME_W-1:0]     i_time_ms = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic [jclc_pkg::POS_X_W-1:0]    o_square_x;
    logic [jclc_pkg::POS_Y_W-1:0]    o_square_y;
    logic [jclc_pkg::LEVEL_W-1:0]    o_red_level;
    logic [jclc_pkg::LEVEL_W-1:0]    o_blue_level;
    logic                            o_border_on;
    logic                            o_leds_enabled;

    joystick_cursor_led_controller_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_x_sample     (i_x_sample),
        .i_y_sample     (i_y_sample),
        .i_button_id    (i_button_id),
        .i_falling_edge (i_falling_edge),
        .i_time_ms      (i_time_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_square_x     (o_square_x),
        .o_square_y     (o_square_y),
        .o_red_level    (o_red_level),
        .o_blue_level   (o_blue_level),
        .o_border_on    (o_border_on),
        .o_leds_enabled (o_leds_enabled)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state, starting from the values after reset.
    int                              mdl_x = HOME_X;
    int                              mdl_y = HOME_Y;
    logic [jclc_pkg::LEVEL_W-1:0]    mdl_red = '0;
    logic [jclc_pkg::LEVEL_W-1:0]    mdl_blue = '0;
    logic                            mdl_leds = 1'b1;
    logic                            mdl_border = 1'b0;
    logic [jclc_pkg::TIME_W-1:0]     mdl_stick_ms = '0;
    logic [jclc_pkg::TIME_W-1:0]     mdl_a_ms = '0;
    logic [jclc_pkg::DEB_W-1:0]      mdl_stick_deb = jclc_pkg::DEB_W'(jclc_pkg::STICK_DEB_RST);
    logic [jclc_pkg::DEB_W-1:0]      mdl_a_deb = jclc_pkg::DEB_W'(jclc_pkg::BTN_A_DEB_RST);

    t_cursor_state                   expected_cursor_q[$];
    t_table_row                      dir_table[$];
    int                              errors = 0;
    int                              send_pct = 0;
    int                              recv_pct = 0;
    logic [jclc_pkg::SAMPLE_W-1:0]   last_x = jclc_pkg::SAMPLE_W'(jclc_pkg::MID);
    logic [jclc_pkg::SAMPLE_W-1:0]   last_y = jclc_pkg::SAMPLE_W'(jclc_pkg::MID);
    logic [jclc_pkg::TIME_W-1:0]     clock_ms = '0;

    // Step size for one axis: the base inside the dead zone, growing linearly
    // to the maximum at full deflection.
    function automatic int axis_step(input int mag);
        if (mag <= jclc_pkg::DEAD_ZONE)
            return jclc_pkg::STEP_MIN;
        return jclc_pkg::STEP_MIN + ((mag - jclc_pkg::DEAD_ZONE)
               * (jclc_pkg::STEP_MAX - jclc_pkg::STEP_MIN))
               / (jclc_pkg::MID - jclc_pkg::DEAD_ZONE);
    endfunction

    // LED level for one axis: zero inside the dead zone, full at full deflection.
    function automatic logic [jclc_pkg::LEVEL_W-1:0] axis_level(input int mag);
        if (mag <= jclc_pkg::DEAD_ZONE)
            return '0;
        return jclc_pkg::LEVEL_W'(((mag - jclc_pkg::DEAD_ZONE) * jclc_pkg::FULL_LEVEL)
               / (jclc_pkg::MID - jclc_pkg::DEAD_ZONE));
    endfunction

    // Applies one accepted item to the model and returns the state after it.
    task automatic advance_cursor_model(input t_stick_item it, output t_cursor_state r);
        int dx, dy, mx, my, sx, sy;
        logic [jclc_pkg::TIME_W-1:0] elapsed;
        logic [jclc_pkg::TIME_W-1:0] hold_off;
        if (it.cmd == jclc_pkg::CMD_SAMPLE) begin
            dx = int'(it.x) - jclc_pkg::MID;
            dy = int'(it.y) - jclc_pkg::MID;
            mx = (dx < 0) ? -dx : dx;
            my = (dy < 0) ? -dy : dy;
            sx = axis_step(mx);
            sy = axis_step(my);
            if (mx <= jclc_pkg::DEAD_ZONE && my <= jclc_pkg::DEAD_ZONE) begin
                mdl_x = HOME_X;
                mdl_y = HOME_Y;
            end else begin
                // A step that would cross an edge leaves that axis alone.
                if (dx < -jclc_pkg::DEAD_ZONE && mdl_x >= sx)
                    mdl_x -= sx;
                else if (dx > jclc_pkg::DEAD_ZONE
                         && mdl_x <= jclc_pkg::SCREEN_W - jclc_pkg::SQUARE_SIDE - sx)
                    mdl_x += sx;
                // The Y axis is inverted: a low reading moves the square down.
                if (dy < -jclc_pkg::DEAD_ZONE
                    && mdl_y <= jclc_pkg::SCREEN_H - jclc_pkg::SQUARE_SIDE - sy)
                    mdl_y += sy;
                else if (dy > jclc_pkg::DEAD_ZONE && mdl_y >= sy)
                    mdl_y -= sy;
            end
            if (mdl_leds) begin
                mdl_red  = axis_level(mx);
                mdl_blue = axis_level(my);
            end
        end else if (it.btn == jclc_pkg::BTN_STICK) begin
            elapsed  = it.t - mdl_stick_ms;
            hold_off = jclc_pkg::TIME_W'(mdl_stick_deb);
            if (elapsed > hold_off) begin
                if (it.fall)
                    mdl_border = !mdl_border;
                mdl_stick_ms = it.t;
            end
        end else begin
            elapsed  = it.t - mdl_a_ms;
            hold_off = jclc_pkg::TIME_W'(mdl_a_deb);
            if (elapsed > hold_off) begin
                if (it.fall)
                    mdl_leds = !mdl_leds;
                mdl_a_ms = it.t;
            end
        end
        r.sq_x   = mdl_x[jclc_pkg::POS_X_W-1:0];
        r.sq_y   = mdl_y[jclc_pkg::POS_Y_W-1:0];
        r.red    = mdl_red;
        r.blue   = mdl_blue;
        r.border = mdl_border;
        r.leds   = mdl_leds;
    endtask

    // One axis reading, weighted towards the dead zone, its edges and the rails.
    function automatic logic [jclc_pkg::SAMPLE_W-1:0] draw_axis();
        case ($urandom_range(0, 9))
            0, 1, 2: return jclc_pkg::SAMPLE_W'($urandom_range(
                                jclc_pkg::MID - jclc_pkg::DEAD_ZONE,
                                jclc_pkg::MID + jclc_pkg::DEAD_ZONE));
            3: begin
                case ($urandom_range(0, 3))
                    0: return jclc_pkg::SAMPLE_W'(jclc_pkg::MID - jclc_pkg::DEAD_ZONE - 1);
                    1: return jclc_pkg::SAMPLE_W'(jclc_pkg::MID - jclc_pkg::DEAD_ZONE);
                    2: return jclc_pkg::SAMPLE_W'(jclc_pkg::MID + jclc_pkg::DEAD_ZONE);
                    default: return jclc_pkg::SAMPLE_W'(jclc_pkg::MID + jclc_pkg::DEAD_ZONE + 1);
                endcase
            end
            4: return ($urandom_range(0, 1) != 0) ? jclc_pkg::SAMPLE_W'(SAMPLE_TOP) : '0;
            default: return jclc_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
        endcase
    endfunction

    // Random item: mostly samples and button edges on a running millisecond
    // clock, with a little noise in which every field is random.
    task automatic draw_item(output t_stick_item it);
        int pick;
        pick    = $urandom_range(0, 99);
        it.cmd  = 1'($urandom_range(0, 1));
        it.x    = jclc_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
        it.y    = jclc_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
        it.btn  = 1'($urandom_range(0, 1));
        it.fall = 1'($urandom_range(0, 1));
        it.t    = $urandom;
        if (pick < 5) begin
            return;
        end else if (pick < 62) begin
            it.cmd = jclc_pkg::CMD_SAMPLE;
            // Repeating the last reading pushes the square into the edges.
            if ($urandom_range(0, 9) >= 3) begin
                last_x = draw_axis();
                last_y = draw_axis();
            end
            it.x = last_x;
            it.y = last_y;
        end else begin
            it.cmd = jclc_pkg::CMD_BUTTON;
            case ($urandom_range(0, 19))
                0: clock_ms = $urandom;
                1, 2, 3: begin
                    // Right on the debounce boundary of the chosen button.
                    if (it.btn == jclc_pkg::BTN_STICK)
                        clock_ms = mdl_stick_ms + jclc_pkg::TIME_W'(mdl_stick_deb)
                                 + jclc_pkg::TIME_W'($urandom_range(0, 1));
                    else
                        clock_ms = mdl_a_ms + jclc_pkg::TIME_W'(mdl_a_deb)
                                 + jclc_pkg::TIME_W'($urandom_range(0, 1));
                end
                default: clock_ms = clock_ms + jclc_pkg::TIME_W'($urandom_range(0, 1100));
            endcase
            it.t = clock_ms;
        end
    endtask

    task automatic add_row(input t_stick_item it, input logic typed, input t_cursor_state want);
        t_table_row row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        dir_table.push_back(row);
    endtask

    // Offers one item, holds it until the transfer and records its result.
    task automatic put_item(input t_stick_item it, input logic typed, input t_cursor_state want);
        t_cursor_state got;
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= it.cmd;
        i_x_sample     <= it.x;
        i_y_sample     <= it.y;
        i_button_id    <= it.btn;
        i_falling_edge <= it.fall;
        i_time_ms      <= it.t;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        advance_cursor_model(it, got);
        expected_cursor_q.push_back(typed ? want : got);
    endtask

    // Lowers valid and waits for every outstanding result, plus the latency.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_cursor_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both debounce registers, joystick first and then button A, in consecutive cycles.
    task automatic write_debounce(input logic [jclc_pkg::DEB_W-1:0] stick_ms,
                                  input logic [jclc_pkg::DEB_W-1:0] a_ms);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= jclc_pkg::CFG_STICK_DEB;
        i_cfg_data <= stick_ms;
        @(posedge i_clk);
        i_cfg_idx  <= jclc_pkg::CFG_BTN_A_DEB;
        i_cfg_data <= a_ms;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mdl_stick_deb = stick_ms;
        mdl_a_deb     = a_ms;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: compare each transfer with the oldest expectation, then
    // decide whether to stall on the next cycle.
    always @(posedge i_clk) begin
        t_cursor_state want;
        if (o_valid && i_ready) begin
            if (expected_cursor_q.size() == 0) begin
                $display("%0t ns: result with nothing expected, actual x %0d y %0d",
                         $time, o_square_x, o_square_y);
                errors++;
            end else begin
                want = expected_cursor_q.pop_front();
                check_field("square_x", 32'(want.sq_x), 32'(o_square_x));
                check_field("square_y", 32'(want.sq_y), 32'(o_square_y));
                check_field("red_level", 32'(want.red), 32'(o_red_level));
                check_field("blue_level", 32'(want.blue), 32'(o_blue_level));
                check_field("border_on", 32'(want.border), 32'(o_border_on));
                check_field("leds_enabled", 32'(want.leds), 32'(o_leds_enabled));
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // Stimulus sequence.
    initial begin
        t_stick_item it;
        int p;
        int k;

        // Directed table. Rows with a typed result follow directly from the
        // reset state, the rails or the debounce boundaries.
        // Reset state, then full deflection on each axis alone.
        add_row({jclc_pkg::CMD_SAMPLE, 12'd2048, 12'd2048, jclc_pkg::BTN_A, 1'b1,
                 32'hFFFF_FFFF}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b0, 1'b1});
        add_row({jclc_pkg::CMD_SAMPLE, 12'd0, 12'd2048, jclc_pkg::BTN_A, 1'b1, 32'h0}, 1'b1,
                {7'd44, 6'd28, 12'd4000, 12'd0, 1'b0, 1'b1});
        add_row({jclc_pkg::CMD_SAMPLE, 12'd2048, 12'd0, jclc_pkg::BTN_STICK, 1'b0,
                 32'h8000_0000}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd4000, 1'b0, 1'b1});
        // Both axes on the dead-zone edge: the square goes home.
        add_row({jclc_pkg::CMD_SAMPLE, 12'd1548, 12'd2548, jclc_pkg::BTN_A, 1'b0, 32'd77}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b0, 1'b1});
        // Joystick button: exactly on the hold-off, one past it, rising edges
        // that move the timestamp without toggling.
        add_row({jclc_pkg::CMD_BUTTON, 12'd4095, 12'd4095, jclc_pkg::BTN_STICK, 1'b1,
                 32'd50}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b0, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd0, 12'd4095, jclc_pkg::BTN_STICK, 1'b1,
                 32'd51}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b1, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd4095, 12'd0, jclc_pkg::BTN_STICK, 1'b0,
                 32'd100}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b1, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd4095, 12'd0, jclc_pkg::BTN_STICK, 1'b0,
                 32'd102}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b1, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd0, 12'd0, jclc_pkg::BTN_STICK, 1'b1,
                 32'd140}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b1, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd0, 12'd0, jclc_pkg::BTN_STICK, 1'b1,
                 32'd153}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b0, 1'b1});
        // Button A switches the LED drive off; levels then hold.
        add_row({jclc_pkg::CMD_BUTTON, 12'd4095, 12'd4095, jclc_pkg::BTN_A, 1'b1,
                 32'd81}, 1'b1,
                {7'd60, 6'd28, 12'd0, 12'd0, 1'b0, 1'b0});
        add_row({jclc_pkg::CMD_SAMPLE, 12'd0, 12'd0, jclc_pkg::BTN_A, 1'b1, 32'd0}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b0, 1'b0});
        add_row({jclc_pkg::CMD_BUTTON, 12'd0, 12'd0, jclc_pkg::BTN_A, 1'b1, 32'd161}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b0, 1'b0});
        add_row({jclc_pkg::CMD_BUTTON, 12'd0, 12'd0, jclc_pkg::BTN_A, 1'b1, 32'd162}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b0, 1'b1});
        // Timestamps wrapping through zero.
        add_row({jclc_pkg::CMD_BUTTON, 12'd2048, 12'd2048, jclc_pkg::BTN_STICK, 1'b1,
                 32'hFFFF_FFF0}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b1, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd2048, 12'd2048, jclc_pkg::BTN_STICK, 1'b1,
                 32'h0000_0020}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b1, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd2048, 12'd2048, jclc_pkg::BTN_STICK, 1'b1,
                 32'h0000_0023}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b0, 1'b1});
        add_row({jclc_pkg::CMD_BUTTON, 12'd2048, 12'd2048, jclc_pkg::BTN_A, 1'b0,
                 32'h0000_0023}, 1'b1,
                {7'd44, 6'd44, 12'd0, 12'd0, 1'b0, 1'b1});
        // Near-full deflection, just outside the dead zone, then moves that
        // run into the left and top edges and stop there.
        add_row({jclc_pkg::CMD_SAMPLE, 12'd4095, 12'd4095, jclc_pkg::BTN_STICK, 1'b1, 32'd5},
                1'b0, '0);
        add_row({jclc_pkg::CMD_SAMPLE, 12'd1547, 12'd2549, jclc_pkg::BTN_STICK, 1'b0, 32'd5},
                1'b0, '0);
        for (k = 0; k < 4; k++)
            add_row({jclc_pkg::CMD_SAMPLE, 12'd0, 12'd2048, jclc_pkg::BTN_A, 1'b0, 32'd9},
                    1'b0, '0);
        for (k = 0; k < 2; k++)
            add_row({jclc_pkg::CMD_SAMPLE, 12'd2048, 12'd4095, jclc_pkg::BTN_A, 1'b1, 32'd9},
                    1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < dir_table.size(); k++)
            put_item(dir_table[k].item, dir_table[k].typed, dir_table[k].want);

        // Random phases, each with its own debounce settings and idling.
        for (p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: write_debounce(jclc_pkg::DEB_W'(0), jclc_pkg::DEB_W'(1023));
                1: write_debounce(jclc_pkg::DEB_W'(1000), jclc_pkg::DEB_W'(0));
                2: write_debounce(jclc_pkg::DEB_W'($urandom_range(0, 1023)),
                                  jclc_pkg::DEB_W'($urandom_range(0, 1023)));
                default: write_debounce(jclc_pkg::DEB_W'(1023), jclc_pkg::DEB_W'(1000));
            endcase
            case (p)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 55; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 55; end
                default: begin send_pct = 16; recv_pct = 16; end
            endcase
            repeat (PHASE_ITEMS) begin
                draw_item(it);
                put_item(it, 1'b0, '0);
            end
        end
        settle();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
